// ===== rtl/core/tmqe_pkg.sv =====
package tmqe_pkg;

  // operation codes
  localparam logic [1:0] OP_OPEN  = 2'd0;
  localparam logic [1:0] OP_CLOSE = 2'd1;
  localparam logic [1:0] OP_SEND  = 2'd2;
  localparam logic [1:0] OP_RECV  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FAIL  = 2'd1;
  localparam logic [1:0] ST_BLOCK = 2'd2;

  // flag bit positions
  localparam int FL_CREATE = 0;
  localparam int FL_EXCL   = 1;
  localparam int FL_NOWAIT = 2;
  localparam int FL_NOERR  = 3;

  localparam logic [11:0] MAXVOL_RESET = 12'd1024;
  localparam logic [11:0] VOL_SAT      = 12'hfff;
  localparam logic [7:0]  OPEN_SAT     = 8'hff;

  // assembly buffer status
  typedef struct packed {
    logic [4:0] count;
    logic [7:0] length;
  } asm_stat_t;

  // one stored message header
  typedef struct packed {
    logic [63:0] mtype;
    logic [7:0]  mlen;
  } meta_t;

endpackage

// ===== rtl/core/tmqe_asm.sv =====
module tmqe_asm
  import tmqe_pkg::*;
#(
  parameter int TEXT_WORDS = 16,
  parameter int TEXT_CAP   = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  logic [63:0] wr_word,
  input  logic        clr,
  input  logic [4:0]  rd_idx,
  output logic [63:0] rd_word,
  output asm_stat_t   stat
);

  localparam int IW = (TEXT_WORDS > 1) ? $clog2(TEXT_WORDS) : 1;

  logic [63:0] words_r [TEXT_WORDS];
  logic [4:0]  count_r;
  logic        found_r;
  logic [7:0]  flen_r;
  logic        room;
  logic        zhit;
  logic [2:0]  zpos;
  logic [7:0]  cand;

  assign room = count_r < 5'(TEXT_WORDS);

  // first zero byte of the incoming word
  always_comb begin
    zhit = 1'b0;
    zpos = 3'd0;
    for (int b = 7; b >= 0; b--) begin
      if (wr_word[8*b +: 8] == 8'd0) begin
        zhit = 1'b1;
        zpos = 3'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      found_r <= 1'b0;
      flen_r  <= '0;
    end else if (clr) begin
      count_r <= '0;
      found_r <= 1'b0;
    end else if (wr_en && room) begin
      count_r <= count_r + 5'd1;
      if (!found_r && zhit) begin
        found_r <= 1'b1;
        flen_r  <= {count_r, 3'b000} + {5'd0, zpos};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && room) begin
      words_r[count_r[IW-1:0]] <= wr_word;
    end
  end

  assign cand        = found_r ? flen_r : {count_r, 3'b000};
  assign stat.count  = count_r;
  assign stat.length = (cand > 8'(TEXT_CAP)) ? 8'(TEXT_CAP) : cand;
  assign rd_word     = (rd_idx < count_r) ? words_r[rd_idx[IW-1:0]] : 64'd0;

endmodule

// ===== rtl/core/tmqe_slot_mem.sv =====
module tmqe_slot_mem
  import tmqe_pkg::*;
#(
  parameter int MA_W   = 8,
  parameter int TA_W   = 12,
  parameter int MDEPTH = 160,
  parameter int TDEPTH = 2560
) (
  input  logic            clk,
  input  logic            meta_we,
  input  logic [MA_W-1:0] meta_waddr,
  input  meta_t           meta_wdata,
  input  logic            meta_re,
  input  logic [MA_W-1:0] meta_raddr,
  output meta_t           meta_rdata,
  input  logic            text_we,
  input  logic [TA_W-1:0] text_waddr,
  input  logic [63:0]     text_wdata,
  input  logic            text_re,
  input  logic [TA_W-1:0] text_raddr,
  output logic [63:0]     text_rdata
);

  meta_t       meta_mem [MDEPTH];
  logic [63:0] text_mem [TDEPTH];

  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    if (meta_re) begin
      meta_rdata <= meta_mem[meta_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (text_we) begin
      text_mem[text_waddr] <= text_wdata;
    end
    if (text_re) begin
      text_rdata <= text_mem[text_raddr];
    end
  end

endmodule

// ===== rtl/core/typed_message_queue_engine_top.sv =====
// Typed mailbox engine. An item is taken when start is high and busy is low;
// results come out on out_valid for one cycle each and cannot be held off,
// so the receiver must take every cycle that out_valid marks. Open and close
// go through S_OPEN or S_CLOSE and give a registered result. A send word that
// is not the last one is taken with no result and busy stays low. The last
// send word goes through S_SEND and then S_COPY, which writes every text word
// slot, zero past the sent words, into the text memory through its single
// write port. Receive checks the stored headers of the mailbox in slot order,
// one header read per cycle, to find the first message of the asked type, and
// then streams its words, one text memory read per cycle.
// Results of one receive leave back to back on consecutive cycles.
module typed_message_queue_engine_top
  import tmqe_pkg::*;
#(
  parameter int NUM_MAILBOXES = 10,
  parameter int MAX_MESSAGES  = 16,
  parameter int TEXT_BYTES    = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  // item input
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [3:0]  in_queue_key,
  input  logic [3:0]  in_flags,
  input  logic [7:0]  in_size_limit,
  input  logic signed [63:0] in_msg_type,
  input  logic [63:0] in_text_word,
  input  logic        in_last_word,
  // results
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [3:0]  out_queue_id,
  output logic [7:0]  out_text_length,
  output logic signed [63:0] out_type,
  output logic [63:0] out_word,
  output logic        out_last_result,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] cfg_max_volume
);

  // derived sizes
  localparam int RAW_WORDS  = (TEXT_BYTES + 7) / 8;
  localparam int TEXT_WORDS = (RAW_WORDS > 16) ? 16 : RAW_WORDS;
  localparam int TEXT_CAP   = (TEXT_BYTES < TEXT_WORDS * 8) ? TEXT_BYTES : TEXT_WORDS * 8;
  localparam int KW     = (NUM_MAILBOXES > 1) ? $clog2(NUM_MAILBOXES) : 1;
  localparam int PW     = (MAX_MESSAGES > 1) ? $clog2(MAX_MESSAGES) : 1;
  localparam int WW     = (TEXT_WORDS > 1) ? $clog2(TEXT_WORDS) : 1;
  localparam int CW     = $clog2(MAX_MESSAGES + 1);
  localparam int MA_W   = KW + PW;
  localparam int TA_W   = MA_W + WW;
  localparam int MDEPTH = NUM_MAILBOXES << PW;
  localparam int TDEPTH = MDEPTH << WW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OPEN,
    S_CLOSE,
    S_SEND,
    S_COPY,
    S_RCHK,
    S_RCMP,
    S_RSTR
  } state_t;

  typedef logic [MAX_MESSAGES-1:0][PW-1:0] row_t;

  state_t state_r;

  // per mailbox counters and slot order, one row per mailbox
  logic [7:0]    open_cnt_r [NUM_MAILBOXES];
  logic [CW-1:0] msg_cnt_r  [NUM_MAILBOXES];
  logic [11:0]   vol_r      [NUM_MAILBOXES];
  row_t          order_r    [NUM_MAILBOXES];
  logic [11:0]   maxvol_r;

  // the item in work
  logic [3:0]  key_r;
  logic        ok_r;
  logic [3:0]  flags_r;
  logic [7:0]  size_r;
  logic [63:0] type_r;

  // send and receive progress
  logic [PW-1:0] phys_r;
  logic [PW-1:0] p_r;
  logic [4:0]    cw_r;
  logic [4:0]    wi_r;
  logic [4:0]    we_r;
  logic          rdv_r;
  logic [4:0]    words_r;
  logic [7:0]    dlen_r;
  logic [7:0]    slen_r;

  // output register
  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic [3:0]  out_queue_id_r;
  logic [7:0]  out_text_length_r;
  logic [63:0] out_type_r;
  logic [63:0] out_word_r;
  logic        out_last_r;

  logic          acc;
  logic [KW-1:0] kidx;
  row_t          row;
  logic [7:0]    oc;
  logic [CW-1:0] mc;
  logic [11:0]   vol;
  logic          grant;
  logic          send_full;
  logic          send_over;
  logic [12:0]   vol_add;
  logic [11:0]   vol_add_sat;
  logic [11:0]   vol_sub;
  logic [PW:0]   p_next;
  logic          type_hit;
  logic          too_long;
  logic [7:0]    dlen;
  logic [5:0]    wcalc;
  logic [4:0]    words_calc;
  logic          issue;
  logic [7:0]    wbase;
  logic [7:0]    rem;
  logic          last_emit;
  row_t          row_rm;

  logic            asm_wr;
  logic            asm_clr;
  logic [63:0]     asm_word;
  asm_stat_t       asm_stat;
  logic            meta_we;
  logic            meta_re;
  logic [MA_W-1:0] meta_raddr;
  meta_t           meta_wdata;
  meta_t           meta_rdata;
  logic            text_re;
  logic [63:0]     text_rdata;

  // bytes past rem cleared
  function automatic logic [63:0] keep_bytes(input logic [63:0] w, input logic [7:0] n);
    logic [63:0] r;
    r = w;
    for (int b = 0; b < 8; b++) begin
      if (8'(b) >= n) begin
        r[8*b +: 8] = 8'd0;
      end
    end
    return r;
  endfunction

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = !busy;
  assign acc       = start && !busy;
  assign asm_wr    = acc && (in_op == OP_SEND);

  assign kidx = key_r[KW-1:0];
  assign row  = order_r[kidx];
  assign oc   = open_cnt_r[kidx];
  assign mc   = msg_cnt_r[kidx];
  assign vol  = vol_r[kidx];

  // open: exclusive needs a closed mailbox, plain join needs create
  assign grant = ok_r && (oc != OPEN_SAT) &&
                 (flags_r[FL_EXCL] ? (oc == 8'd0) : flags_r[FL_CREATE]);

  // send admission
  assign send_full   = (mc >= CW'(MAX_MESSAGES));
  assign send_over   = ({1'b0, vol} + {5'd0, size_r}) > {1'b0, maxvol_r};
  assign vol_add     = {1'b0, vol} + {5'd0, asm_stat.length};
  assign vol_add_sat = vol_add[12] ? VOL_SAT : vol_add[11:0];
  assign vol_sub     = (vol > {4'd0, slen_r}) ? (vol - {4'd0, slen_r}) : 12'd0;

  // receive lookup
  assign p_next   = {1'b0, p_r} + {{PW{1'b0}}, 1'b1};
  assign type_hit = (meta_rdata.mtype == type_r);
  assign too_long = (meta_rdata.mlen > size_r);
  assign dlen     = too_long ? size_r : meta_rdata.mlen;
  assign wcalc    = 6'(({1'b0, dlen} + 9'd7) >> 3);

  always_comb begin
    words_calc = wcalc[4:0];
    if (wcalc == 6'd0) begin
      words_calc = 5'd1;
    end else if (wcalc > 6'(TEXT_WORDS)) begin
      words_calc = 5'(TEXT_WORDS);
    end
  end

  // receive streaming
  assign issue     = (state_r == S_RSTR) && (wi_r < words_r);
  assign text_re   = issue;
  assign wbase     = {we_r, 3'b000};
  assign rem       = (dlen_r > wbase) ? (dlen_r - wbase) : 8'd0;
  assign last_emit = (we_r + 5'd1 == words_r);

  // slot order with the taken entry moved behind the live ones
  always_comb begin
    for (int q = 0; q < MAX_MESSAGES; q++) begin
      if (PW'(q) < p_r) begin
        row_rm[q] = row[q];
      end else if (CW'(q + 1) < mc && q < MAX_MESSAGES - 1) begin
        row_rm[q] = row[(q + 1) % MAX_MESSAGES];
      end else if (CW'(q + 1) == mc) begin
        row_rm[q] = phys_r;
      end else begin
        row_rm[q] = row[q];
      end
    end
  end

  // memory side controls
  assign asm_clr          = ((state_r == S_SEND) && (!ok_r || oc == 8'd0 || send_full ||
                             send_over)) ||
                            ((state_r == S_COPY) && (cw_r == 5'(TEXT_WORDS - 1)));
  assign meta_we          = (state_r == S_SEND) && ok_r && (oc != 8'd0) && !send_full &&
                            !send_over;
  assign meta_wdata.mtype = type_r;
  assign meta_wdata.mlen  = asm_stat.length;

  always_comb begin
    meta_re    = 1'b0;
    meta_raddr = {kidx, row[0]};
    case (state_r)
      S_RCHK: begin
        meta_re = 1'b1;
      end
      S_RCMP: begin
        meta_re    = 1'b1;
        meta_raddr = {kidx, row[p_next[PW-1:0]]};
      end
      default: begin
        meta_re = 1'b0;
      end
    endcase
  end

  tmqe_asm #(
    .TEXT_WORDS(TEXT_WORDS),
    .TEXT_CAP  (TEXT_CAP)
  ) u_asm (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (asm_wr),
    .wr_word(in_text_word),
    .clr    (asm_clr),
    .rd_idx (cw_r),
    .rd_word(asm_word),
    .stat   (asm_stat)
  );

  tmqe_slot_mem #(
    .MA_W  (MA_W),
    .TA_W  (TA_W),
    .MDEPTH(MDEPTH),
    .TDEPTH(TDEPTH)
  ) u_mem (
    .clk       (clk),
    .meta_we   (meta_we),
    .meta_waddr({kidx, row[mc[PW-1:0]]}),
    .meta_wdata(meta_wdata),
    .meta_re   (meta_re),
    .meta_raddr(meta_raddr),
    .meta_rdata(meta_rdata),
    .text_we   (state_r == S_COPY),
    .text_waddr({kidx, phys_r, cw_r[WW-1:0]}),
    .text_wdata(asm_word),
    .text_re   (text_re),
    .text_raddr({kidx, phys_r, wi_r[WW-1:0]}),
    .text_rdata(text_rdata)
  );

  // control, counters and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      maxvol_r    <= MAXVOL_RESET;
      out_valid_r <= 1'b0;
      rdv_r       <= 1'b0;
      for (int m = 0; m < NUM_MAILBOXES; m++) begin
        open_cnt_r[m] <= '0;
        msg_cnt_r[m]  <= '0;
        vol_r[m]      <= '0;
        for (int s = 0; s < MAX_MESSAGES; s++) begin
          order_r[m][s] <= PW'(s);
        end
      end
    end else begin
      out_valid_r <= 1'b0;
      rdv_r       <= issue;
      if (cfg_valid && cfg_ready) begin
        maxvol_r <= cfg_max_volume;
      end
      case (state_r)
        S_IDLE: begin
          if (acc) begin
            key_r   <= in_queue_key;
            ok_r    <= (5'(in_queue_key) < 5'(NUM_MAILBOXES));
            flags_r <= in_flags;
            size_r  <= in_size_limit;
            type_r  <= in_msg_type;
            case (in_op)
              OP_OPEN:  state_r <= S_OPEN;
              OP_CLOSE: state_r <= S_CLOSE;
              OP_SEND:  state_r <= in_last_word ? S_SEND : S_IDLE;
              OP_RECV:  state_r <= S_RCHK;
              default:  state_r <= S_IDLE;
            endcase
          end
        end
        S_OPEN: begin
          if (grant) begin
            open_cnt_r[kidx] <= oc + 8'd1;
          end
          out_valid_r       <= 1'b1;
          out_status_r      <= grant ? ST_OK : ST_FAIL;
          out_queue_id_r    <= grant ? key_r : 4'd0;
          out_text_length_r <= '0;
          out_type_r        <= '0;
          out_word_r        <= '0;
          out_last_r        <= 1'b1;
          state_r           <= S_IDLE;
        end
        S_CLOSE: begin
          if (ok_r && oc != 8'd0) begin
            open_cnt_r[kidx] <= oc - 8'd1;
          end
          out_valid_r       <= 1'b1;
          out_status_r      <= (ok_r && oc != 8'd0) ? ST_OK : ST_FAIL;
          out_queue_id_r    <= '0;
          out_text_length_r <= '0;
          out_type_r        <= '0;
          out_word_r        <= '0;
          out_last_r        <= 1'b1;
          state_r           <= S_IDLE;
        end
        S_SEND: begin
          out_queue_id_r    <= '0;
          out_text_length_r <= '0;
          out_type_r        <= '0;
          out_word_r        <= '0;
          out_last_r        <= 1'b1;
          if (!ok_r || oc == 8'd0) begin
            out_valid_r  <= 1'b1;
            out_status_r <= ST_FAIL;
            state_r      <= S_IDLE;
          end else if (send_full || send_over) begin
            out_valid_r  <= 1'b1;
            out_status_r <= flags_r[FL_NOWAIT] ? ST_FAIL : ST_BLOCK;
            state_r      <= S_IDLE;
          end else begin
            phys_r          <= row[mc[PW-1:0]];
            msg_cnt_r[kidx] <= mc + CW'(1);
            vol_r[kidx]     <= vol_add_sat;
            cw_r            <= '0;
            state_r         <= S_COPY;
          end
        end
        S_COPY: begin
          // one text word per cycle, zero past the sent words
          cw_r <= cw_r + 5'd1;
          if (cw_r == 5'(TEXT_WORDS - 1)) begin
            out_valid_r  <= 1'b1;
            out_status_r <= ST_OK;
            state_r      <= S_IDLE;
          end
        end
        S_RCHK: begin
          out_queue_id_r    <= '0;
          out_text_length_r <= '0;
          out_type_r        <= '0;
          out_word_r        <= '0;
          out_last_r        <= 1'b1;
          p_r               <= '0;
          if (!ok_r || oc == 8'd0) begin
            out_valid_r  <= 1'b1;
            out_status_r <= ST_FAIL;
            state_r      <= S_IDLE;
          end else if (mc == '0) begin
            out_valid_r  <= 1'b1;
            out_status_r <= flags_r[FL_NOWAIT] ? ST_FAIL : ST_BLOCK;
            state_r      <= S_IDLE;
          end else begin
            state_r <= S_RCMP;
          end
        end
        S_RCMP: begin
          // header of entry p_r is on the read port, next one is fetched
          if (type_hit) begin
            if (too_long && !flags_r[FL_NOERR]) begin
              out_valid_r  <= 1'b1;
              out_status_r <= ST_FAIL;
              state_r      <= S_IDLE;
            end else begin
              phys_r  <= row[p_r];
              dlen_r  <= dlen;
              slen_r  <= meta_rdata.mlen;
              words_r <= words_calc;
              wi_r    <= '0;
              we_r    <= '0;
              state_r <= S_RSTR;
            end
          end else if (p_next == (PW + 1)'(mc)) begin
            out_valid_r  <= 1'b1;
            out_status_r <= ST_FAIL;
            state_r      <= S_IDLE;
          end else begin
            p_r <= p_next[PW-1:0];
          end
        end
        S_RSTR: begin
          if (issue) begin
            wi_r <= wi_r + 5'd1;
          end
          if (rdv_r) begin
            out_valid_r       <= 1'b1;
            out_status_r      <= ST_OK;
            out_queue_id_r    <= '0;
            out_text_length_r <= dlen_r;
            out_type_r        <= type_r;
            out_word_r        <= keep_bytes(text_rdata, rem);
            out_last_r        <= last_emit;
            we_r              <= we_r + 5'd1;
            if (last_emit) begin
              order_r[kidx]   <= row_rm;
              msg_cnt_r[kidx] <= mc - CW'(1);
              vol_r[kidx]     <= vol_sub;
              state_r         <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_queue_id    = out_queue_id_r;
  assign out_text_length = out_text_length_r;
  assign out_type        = out_type_r;
  assign out_word        = out_word_r;
  assign out_last_result = out_last_r;

endmodule

// ===== rtl/core/tmqe_checker.sv =====
module tmqe_checker
  import tmqe_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [1:0] in_op,
  input logic       in_last_word,
  input logic       out_valid,
  input logic [1:0] out_status,
  input logic [3:0] out_queue_id,
  input logic [7:0] out_text_length,
  input logic       out_last_result
);

  // a refused item gives one bare result
  a_fail_bare: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |->
      out_last_result && out_queue_id == 4'd0 && out_text_length == 8'd0)
    else $error("refused item result not bare");

  // received words leave back to back with one length
  a_stream: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_result |=>
      out_valid && out_status == ST_OK && $stable(out_text_length))
    else $error("receive stream broken");

  // receive always holds the block
  a_recv_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_op == OP_RECV |=> busy)
    else $error("receive did not raise busy");

  // inner send word gives no result
  a_word_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_op == OP_SEND && !in_last_word |=> !out_valid && !busy)
    else $error("inner send word produced activity");

endmodule

bind typed_message_queue_engine_top tmqe_checker u_tmqe_checker (.*);

// ===== tb/typed_message_queue_engine_checker.sv =====
module typed_message_queue_engine_checker
  import tmqe_pkg::*;
#(
  parameter int NUM_MAILBOXES = 10,
  parameter int MAX_MESSAGES  = 16,
  parameter int TEXT_BYTES    = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  in_op,
  input  logic [3:0]  in_queue_key,
  input  logic [3:0]  in_flags,
  input  logic [7:0]  in_size_limit,
  input  logic [63:0] in_msg_type,
  input  logic [63:0] in_text_word,
  input  logic        in_last_word,
  input  logic        out_valid,
  input  logic [1:0]  out_status,
  input  logic [3:0]  out_queue_id,
  input  logic [7:0]  out_text_length,
  input  logic [63:0] out_type,
  input  logic [63:0] out_word,
  input  logic        out_last_result,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [11:0] cfg_max_volume,
  output int          pending,
  output int          fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORDS = (TEXT_BYTES + 7) / 8 > 16 ? 16 : (TEXT_BYTES + 7) / 8;
  localparam int CAP   = TEXT_BYTES < WORDS * 8 ? TEXT_BYTES : WORDS * 8;

  typedef struct {
    logic [1:0]  status;
    logic [3:0]  qid;
    logic [7:0]  len;
    logic [63:0] mtype;
    logic [63:0] word;
    logic        last;
  } reply_t;

  reply_t      reply_q[$];
  logic [11:0] max_vol;
  logic [7:0]  opens   [NUM_MAILBOXES];
  int          msgs    [NUM_MAILBOXES];
  int          vol     [NUM_MAILBOXES];
  int          order   [NUM_MAILBOXES][MAX_MESSAGES];
  logic [63:0] stype   [NUM_MAILBOXES][MAX_MESSAGES];
  int          slen    [NUM_MAILBOXES][MAX_MESSAGES];
  logic [63:0] stext   [NUM_MAILBOXES][MAX_MESSAGES][WORDS];
  logic [63:0] asm_buf [WORDS];
  int          asm_idx;

  task automatic post(logic [1:0] st, logic [3:0] id, logic [7:0] len,
                      logic [63:0] ty, logic [63:0] w, logic last);
    reply_t r;
    r.status = st; r.qid = id; r.len = len; r.mtype = ty; r.word = w; r.last = last;
    reply_q.push_back(r);
  endtask

  function automatic int text_len();
    logic [63:0] w;
    for (int i = 0; i < WORDS; i++) begin
      w = (i < asm_idx) ? asm_buf[i] : 64'd0;
      for (int b = 0; b < 8; b++) begin
        if (i * 8 + b >= CAP) return CAP;
        if (w[8*b +: 8] == 8'd0) return i * 8 + b;
      end
    end
    return CAP;
  endfunction

  task automatic store_msg(int key, logic [3:0] flags, int size, logic [63:0] ty);
    int len, phys;
    if (msgs[key] >= MAX_MESSAGES || vol[key] + size > max_vol) begin
      post(flags[FL_NOWAIT] ? ST_FAIL : ST_BLOCK, 0, 0, 0, 0, 1'b1);
      return;
    end
    len = text_len();
    phys = order[key][msgs[key]];
    stype[key][phys] = ty;
    slen[key][phys] = len;
    for (int i = 0; i < WORDS; i++) stext[key][phys][i] = (i < asm_idx) ? asm_buf[i] : 64'd0;
    msgs[key]++;
    vol[key] = (vol[key] + len > 4095) ? 4095 : vol[key] + len;
    post(ST_OK, 0, 0, 0, 0, 1'b1);
  endtask

  task automatic fetch_msg(int key, logic [3:0] flags, int size, logic [63:0] ty);
    int phys, len, nw, rem;
    logic [63:0] w;
    if (msgs[key] == 0) begin
      post(flags[FL_NOWAIT] ? ST_FAIL : ST_BLOCK, 0, 0, 0, 0, 1'b1);
      return;
    end
    for (int p = 0; p < msgs[key]; p++) begin
      phys = order[key][p];
      if (stype[key][phys] != ty) continue;
      len = slen[key][phys];
      if (len > size) begin
        if (!flags[FL_NOERR]) begin
          post(ST_FAIL, 0, 0, 0, 0, 1'b1);
          return;
        end
        len = size;
      end
      nw = (len + 7) / 8;
      if (nw == 0) nw = 1;
      if (nw > WORDS) nw = WORDS;
      for (int i = 0; i < nw; i++) begin
        rem = (len > i * 8) ? len - i * 8 : 0;
        w = stext[key][phys][i];
        if (rem < 8) w = w & ((64'd1 << (8 * rem)) - 64'd1);
        post(ST_OK, 0, len[7:0], ty, w, i + 1 == nw);
      end
      // free slot moves behind the remaining ones
      for (int q = p; q + 1 < msgs[key]; q++) order[key][q] = order[key][q + 1];
      order[key][msgs[key] - 1] = phys;
      msgs[key]--;
      vol[key] = (vol[key] > slen[key][phys]) ? vol[key] - slen[key][phys] : 0;
      return;
    end
    post(ST_FAIL, 0, 0, 0, 0, 1'b1);
  endtask

  task automatic predict_item();
    int key;
    logic ok;
    logic grant;
    key = in_queue_key;
    ok = key < NUM_MAILBOXES;
    case (in_op)
      OP_OPEN: begin
        grant = 1'b0;
        if (ok && opens[key] != OPEN_SAT)
          grant = in_flags[FL_EXCL] ? (opens[key] == 0) : in_flags[FL_CREATE];
        if (grant) begin
          opens[key]++;
          post(ST_OK, key[3:0], 0, 0, 0, 1'b1);
        end else post(ST_FAIL, 0, 0, 0, 0, 1'b1);
      end
      OP_CLOSE: begin
        if (!ok || opens[key] == 0) post(ST_FAIL, 0, 0, 0, 0, 1'b1);
        else begin
          opens[key]--;
          post(ST_OK, 0, 0, 0, 0, 1'b1);
        end
      end
      OP_SEND: begin
        if (asm_idx < WORDS) asm_buf[asm_idx++] = in_text_word;
        if (in_last_word) begin
          if (!ok || opens[key] == 0) post(ST_FAIL, 0, 0, 0, 0, 1'b1);
          else store_msg(key, in_flags, in_size_limit, in_msg_type);
          asm_idx = 0;
        end
      end
      default: begin
        if (!ok || opens[key] == 0) post(ST_FAIL, 0, 0, 0, 0, 1'b1);
        else fetch_msg(key, in_flags, in_size_limit, in_msg_type);
      end
    endcase
  endtask

  always @(posedge clk) begin
    reply_t e;
    if (!rst_n) begin
      reply_q.delete();
      max_vol = MAXVOL_RESET;
      asm_idx = 0;
      for (int m = 0; m < NUM_MAILBOXES; m++) begin
        opens[m] = 0; msgs[m] = 0; vol[m] = 0;
        for (int s = 0; s < MAX_MESSAGES; s++) order[m][s] = s;
      end
    end else begin
      if (cfg_valid && cfg_ready) max_vol = cfg_max_volume;
      if (start && !busy) predict_item();
      if (out_valid) begin
        if (reply_q.size() == 0) begin
          $display("%0t: unexpected result status %0d word %h", $time, out_status, out_word);
          fail_count <= fail_count + 1;
        end else begin
          e = reply_q.pop_front();
          if (e.status !== out_status || e.qid !== out_queue_id ||
              e.len !== out_text_length || e.mtype !== out_type ||
              e.word !== out_word || e.last !== out_last_result) begin
            $display("%0t: mismatch expected st=%0d id=%0d len=%0d type=%h word=%h last=%0d",
                     $time, e.status, e.qid, e.len, e.mtype, e.word, e.last);
            $display("%0t:          actual   st=%0d id=%0d len=%0d type=%h word=%h last=%0d",
                     $time, out_status, out_queue_id, out_text_length, out_type,
                     out_word, out_last_result);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= reply_q.size();
  end

  initial fail_count = 0;

endmodule

// ===== tb/tb_typed_message_queue_engine_top.sv =====
module tb_typed_message_queue_engine_top
  import tmqe_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // cycles with no handshake at all before the run is declared hung
  localparam int STALL_LIMIT = 3000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_op;
  logic [3:0]  in_queue_key;
  logic [3:0]  in_flags;
  logic [7:0]  in_size_limit;
  logic [63:0] in_msg_type;
  logic [63:0] in_text_word;
  logic        in_last_word;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [3:0]  out_queue_id;
  logic [7:0]  out_text_length;
  logic [63:0] out_type;
  logic [63:0] out_word;
  logic        out_last_result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [11:0] cfg_max_volume;
  int          pending;
  int          fail_count;
  int          idle_pct;
  int          quiet_cycles;

  typed_message_queue_engine_top u_top (
    .clk, .rst_n, .start, .busy, .in_op, .in_queue_key, .in_flags, .in_size_limit,
    .in_msg_type, .in_text_word, .in_last_word, .out_valid, .out_status,
    .out_queue_id, .out_text_length, .out_type, .out_word, .out_last_result,
    .cfg_valid, .cfg_ready, .cfg_max_volume
  );

  typed_message_queue_engine_checker u_checker (
    .clk, .rst_n, .start, .busy, .in_op, .in_queue_key, .in_flags, .in_size_limit,
    .in_msg_type, .in_text_word, .in_last_word, .out_valid, .out_status,
    .out_queue_id, .out_text_length, .out_type, .out_word, .out_last_result,
    .cfg_valid, .cfg_ready, .cfg_max_volume, .pending, .fail_count
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog: any accepted item, result or register write counts as progress
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one item; start stays high afterwards unless the sender decides to idle
  task automatic issue(logic [1:0] op, logic [3:0] key, logic [3:0] flags,
                       logic [7:0] size, logic [63:0] ty, logic [63:0] w, logic last);
    in_op <= op;
    in_queue_key <= key;
    in_flags <= flags;
    in_size_limit <= size;
    in_msg_type <= ty;
    in_text_word <= w;
    in_last_word <= last;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // hold off until every outstanding result has come out
  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_max_volume(logic [11:0] v);
    cfg_max_volume <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // small pool of types so receives find matches, with extremes and noise
  function automatic logic [63:0] pick_type();
    case ($urandom_range(0, 7))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7fff_ffff_ffff_ffff;
      2: return '1;
      3: return {$urandom, $urandom};
      4: return 64'd5;
      default: return 64'(($urandom_range(0, 2)));
    endcase
  endfunction

  // text word: random bytes, sometimes all nonzero, sometimes with a terminator
  function automatic logic [63:0] pick_text();
    logic [63:0] w;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: w = w | 64'h0101_0101_0101_0101;
      1: w[8*$urandom_range(0, 7) +: 8] = 8'd0;
      default: ;
    endcase
    return w;
  endfunction

  function automatic logic [3:0] hot_key();
    return ($urandom_range(0, 19) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 3));
  endfunction

  task automatic send_msg(logic [3:0] key, int nwords);
    logic [3:0]  flags;
    logic [7:0]  size;
    logic [63:0] ty;
    flags = 4'($urandom);
    size = ($urandom_range(0, 1)) ? 8'($urandom_range(0, 64)) : 8'($urandom);
    ty = pick_type();
    for (int i = 0; i < nwords; i++) begin
      // stray item between words leaves the assembly alone
      if (i > 0 && $urandom_range(0, 19) == 0)
        issue(OP_RECV, hot_key(), 4'($urandom), 8'($urandom), pick_type(), pick_text(), 1'b0);
      issue(OP_SEND, key, flags, size, ty, pick_text(), i == nwords - 1);
    end
  endtask

  task automatic random_items(int n);
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 10)
        issue(OP_OPEN, hot_key(), 4'($urandom) | 4'(($urandom_range(0, 3) != 0)),
              8'($urandom), pick_type(), pick_text(), 1'($urandom));
      else if (sel < 15)
        issue(OP_CLOSE, hot_key(), 4'($urandom), 8'($urandom), pick_type(),
              pick_text(), 1'($urandom));
      else if (sel < 55)
        send_msg(hot_key(), ($urandom_range(0, 9) == 0) ? $urandom_range(15, 18)
                                                        : $urandom_range(1, 4));
      else
        issue(OP_RECV, hot_key(), 4'($urandom),
              ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 20)) : 8'hff,
              pick_type(), pick_text(), 1'($urandom));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_op = OP_OPEN;
    in_queue_key = '0;
    in_flags = '0;
    in_size_limit = '0;
    in_msg_type = '0;
    in_text_word = '0;
    in_last_word = 1'b0;
    cfg_valid = 1'b0;
    cfg_max_volume = '0;
    idle_pct = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: open rules, bad keys, empty and mismatched receives, truncation
    issue(OP_OPEN, 4'd0, 4'b0010, 8'd0, 64'd0, 64'd0, 1'b0);    // exclusive take
    issue(OP_OPEN, 4'd0, 4'b0010, 8'd0, 64'd0, 64'd0, 1'b0);    // exclusive while open
    issue(OP_OPEN, 4'd0, 4'b0001, 8'd0, 64'd0, 64'd0, 1'b0);    // join after exclusive
    issue(OP_OPEN, 4'd1, 4'b0000, 8'd0, 64'd0, 64'd0, 1'b0);    // neither create nor excl
    issue(OP_OPEN, 4'd1, 4'b0001, 8'd0, 64'd0, 64'd0, 1'b0);
    issue(OP_OPEN, 4'd2, 4'b1101, 8'd0, 64'd0, 64'd0, 1'b0);
    issue(OP_OPEN, 4'd3, 4'b1111, 8'hff, '1, '1, 1'b1);
    issue(OP_OPEN, 4'd10, 4'b0001, 8'd0, 64'd0, 64'd0, 1'b0);   // key out of range
    issue(OP_CLOSE, 4'd15, 4'b0000, 8'd0, 64'd0, 64'd0, 1'b0);
    issue(OP_CLOSE, 4'd4, 4'b0000, 8'd0, 64'd0, 64'd0, 1'b0);   // never opened
    issue(OP_SEND, 4'd4, 4'b0000, 8'd0, 64'd1, 64'h41, 1'b1);   // send to closed mailbox
    issue(OP_RECV, 4'd4, 4'b0000, 8'hff, 64'd1, 64'd0, 1'b0);
    issue(OP_RECV, 4'd1, 4'b0100, 8'hff, 64'd0, 64'd0, 1'b0);   // empty, no wait
    issue(OP_RECV, 4'd1, 4'b0000, 8'hff, 64'd0, 64'd0, 1'b0);   // empty, would block
    issue(OP_SEND, 4'd1, 4'b0000, 8'd9, 64'h7fff_ffff_ffff_ffff, 64'h6f6c_6c65_6820_6968, 1'b0);
    issue(OP_SEND, 4'd1, 4'b0000, 8'd9, 64'h7fff_ffff_ffff_ffff, 64'h0000_0000_0000_0021, 1'b1);
    issue(OP_SEND, 4'd1, 4'b0000, 8'd0, 64'h8000_0000_0000_0000, 64'd0, 1'b1);  // empty text
    issue(OP_RECV, 4'd1, 4'b0000, 8'hff, 64'd7, 64'd0, 1'b0);   // no such type
    issue(OP_RECV, 4'd1, 4'b0000, 8'd0, 64'h8000_0000_0000_0000, 64'd0, 1'b0);
    issue(OP_RECV, 4'd1, 4'b0000, 8'd2, 64'h7fff_ffff_ffff_ffff, 64'd0, 1'b0);  // too long
    issue(OP_RECV, 4'd1, 4'b1000, 8'd2, 64'h7fff_ffff_ffff_ffff, 64'd0, 1'b0);  // truncated
    issue(OP_SEND, 4'd12, 4'b0000, 8'd0, 64'd0, 64'h1, 1'b1);
    issue(OP_RECV, 4'd15, 4'b1111, 8'hff, 64'd0, 64'd0, 1'b0);
    drain();

    // open count saturation on one mailbox
    for (int i = 0; i < 256; i++)
      issue(OP_OPEN, 4'd9, 4'b0001, 8'd0, 64'd0, 64'd0, 1'b0);
    drain();

    // phase with a small volume limit, sender idles now and then
    write_max_volume(12'd300);
    idle_pct = 10;
    random_items(10);
    drain();

    // zero volume: only zero-size sends into mailboxes that hold zero volume fit
    write_max_volume(12'd0);
    random_items(4);
    drain();

    // widest limit, sender idles often
    write_max_volume(12'd2048);
    idle_pct = 47;
    random_items(10);
    drain();

    // back to the reset value, back to back items
    write_max_volume(12'd1024);
    idle_pct = 0;
    random_items(10);
    drain();

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
